// ===== sv/risc_subset_single_cycle_core_assert.svh =====
// Assertion macros included by the core's top-level RTL file.
`ifndef RISC_SUBSET_SINGLE_CYCLE_CORE_ASSERT_SVH
`define RISC_SUBSET_SINGLE_CYCLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define RSCC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define RSCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rscc_pkg.sv =====
package rscc_pkg;

   // Request types
   localparam logic [1:0] REQ_EXEC = 2'd0;
   localparam logic [1:0] REQ_LOAD = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   // Opcodes
   localparam logic [5:0] OP_RTYPE = 6'b000000;
   localparam logic [5:0] OP_ADDI  = 6'b001000;
   localparam logic [5:0] OP_BEQ   = 6'b000100;
   localparam logic [5:0] OP_BNE   = 6'b000101;
   localparam logic [5:0] OP_LW    = 6'b100011;
   localparam logic [5:0] OP_SW    = 6'b101011;

   // R-type function codes
   localparam logic [5:0] FN_SLL = 6'b000000;
   localparam logic [5:0] FN_ADD = 6'b100000;
   localparam logic [5:0] FN_SUB = 6'b100010;
   localparam logic [5:0] FN_SLT = 6'b101010;

   localparam int unsigned NUM_REGS = 32;
   localparam logic [4:0]  SAVED_REG = 5'd16;

   typedef enum logic [1:0] {
      MEM_NONE,
      MEM_READ,
      MEM_WRITE
   } mem_op_type;

   // One accepted request beat
   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] instr_word;
      logic [4:0]  mem_index;
      logic [31:0] mem_value;
   } item_type;

   // Decode and execute result for one item
   typedef struct packed {
      logic [15:0] next_pc;
      logic        wr_en;     // register write, already dropped for r0
      logic [4:0]  wr_dest;
      logic [31:0] wr_value;
      mem_op_type  mem_op;
      logic        show_mem;  // read data goes to result_value
      logic [31:0] mem_addr;
      logic [31:0] mem_data;
      logic        bad_opcode;
   } exec_type;

   // Register file write port
   typedef struct packed {
      logic        en;
      logic [4:0]  addr;
      logic [31:0] data;
   } rf_write_type;

   // Result stage contents
   typedef struct packed {
      logic [15:0] next_pc;
      logic        wrote;
      logic [4:0]  dest;
      logic [31:0] value;
      logic        from_mem;
      logic        bad_opcode;
      logic        mem_fault;
   } out_type;

endpackage

// ===== sv/rscc_if.sv =====
// Request channel
interface rscc_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  req_type;
   logic        [31:0] instr_word;
   logic        [4:0]  mem_index;
   logic signed [31:0] mem_value;

   modport source (output valid, req_type, instr_word, mem_index, mem_value,
                   input ready);
   modport sink (input valid, req_type, instr_word, mem_index, mem_value,
                 output ready);
endinterface

// Result channel
interface rscc_rsp_if;
   logic               valid;
   logic               ready;
   logic        [15:0] next_pc;
   logic               wrote_reg;
   logic        [4:0]  dest_reg;
   logic signed [31:0] result_value;
   logic signed [31:0] saved_zero_value;
   logic               bad_opcode;
   logic               mem_fault;

   modport source (output valid, next_pc, wrote_reg, dest_reg, result_value,
                   saved_zero_value, bad_opcode, mem_fault,
                   input ready);
   modport sink (input valid, next_pc, wrote_reg, dest_reg, result_value,
                 saved_zero_value, bad_opcode, mem_fault,
                 output ready);
endinterface

// ===== sv/rscc_regfile.sv =====
// 32 x 32 register file: two registered read ports, one write port.
// Valid bits give reset-to-zero; r0 always reads zero; a write in the
// same cycle as a read is passed through to the read data.
module rscc_regfile (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [4:0]            rd_addr_a,
   input  logic [4:0]            rd_addr_b,
   input  rscc_pkg::rf_write_type wr,
   output logic [31:0]           rd_data_a,
   output logic [31:0]           rd_data_b
);
   import rscc_pkg::*;

   logic [31:0]         mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [31:0]         rd_a_ff;
   logic [31:0]         rd_b_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered reads with write bypass
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (rd_addr_a == 5'd0) begin
            rd_a_ff <= '0;
         end else if (wr.en && wr.addr == rd_addr_a) begin
            rd_a_ff <= wr.data;
         end else if (valid_ff[rd_addr_a]) begin
            rd_a_ff <= mem[rd_addr_a];
         end else begin
            rd_a_ff <= '0;
         end

         if (rd_addr_b == 5'd0) begin
            rd_b_ff <= '0;
         end else if (wr.en && wr.addr == rd_addr_b) begin
            rd_b_ff <= wr.data;
         end else if (valid_ff[rd_addr_b]) begin
            rd_b_ff <= mem[rd_addr_b];
         end else begin
            rd_b_ff <= '0;
         end
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== sv/rscc_alu.sv =====
// Decode and execute for one item: ALU ops, branch target, memory address.
module rscc_alu (
   input  rscc_pkg::item_type item,
   input  logic [31:0]        op_a,
   input  logic [31:0]        op_b,
   input  logic [15:0]        pc,
   output rscc_pkg::exec_type res
);
   import rscc_pkg::*;

   logic [5:0]  opcode;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  shamt;
   logic [5:0]  funct;
   logic [31:0] imm_sx;
   logic [15:0] pc_inc;
   logic [15:0] pc_branch;
   logic        equal;

   assign opcode    = item.instr_word[31:26];
   assign rt        = item.instr_word[20:16];
   assign rd        = item.instr_word[15:11];
   assign shamt     = item.instr_word[10:6];
   assign funct     = item.instr_word[5:0];
   assign imm_sx    = {{16{item.instr_word[15]}}, item.instr_word[15:0]};
   assign pc_inc    = pc + 16'd1;
   assign pc_branch = pc_inc + item.instr_word[15:0];
   assign equal     = (op_a == op_b);

   always_comb begin
      res            = '0;
      res.next_pc    = pc;
      res.mem_op     = MEM_NONE;
      res.mem_addr   = op_a + imm_sx;
      res.mem_data   = op_b;

      unique case (item.req_type)
         REQ_EXEC: begin
            res.next_pc = pc_inc;
            unique case (opcode)
               OP_RTYPE: begin
                  res.wr_dest = rd;
                  res.wr_en   = (rd != 5'd0);
                  unique case (funct)
                     FN_ADD: res.wr_value = op_a + op_b;
                     FN_SUB: res.wr_value = op_a - op_b;
                     FN_SLL: res.wr_value = op_b << shamt;
                     FN_SLT: res.wr_value = {31'd0, $signed(op_a) < $signed(op_b)};
                     default: begin
                        res.wr_en      = 1'b0;
                        res.bad_opcode = 1'b1;
                     end
                  endcase
               end
               OP_ADDI: begin
                  res.wr_dest  = rt;
                  res.wr_en    = (rt != 5'd0);
                  res.wr_value = op_a + imm_sx;
               end
               OP_BEQ: begin
                  if (equal) begin
                     res.next_pc = pc_branch;
                  end
               end
               OP_BNE: begin
                  if (!equal) begin
                     res.next_pc = pc_branch;
                  end
               end
               OP_LW: begin
                  res.mem_op   = MEM_READ;
                  res.wr_dest  = rt;
                  res.wr_en    = (rt != 5'd0);
                  res.show_mem = (rt != 5'd0);
               end
               OP_SW: begin
                  res.mem_op = MEM_WRITE;
               end
               default: begin
                  res.bad_opcode = 1'b1;
               end
            endcase
         end
         REQ_LOAD: begin
            res.mem_op   = MEM_WRITE;
            res.mem_addr = {27'd0, item.mem_index};
            res.mem_data = item.mem_value;
         end
         REQ_READ: begin
            res.mem_op   = MEM_READ;
            res.mem_addr = {27'd0, item.mem_index};
            res.show_mem = 1'b1;
         end
         default: begin
            // idle request: nothing happens
         end
      endcase
   end

endmodule

// ===== sv/risc_subset_single_cycle_core.sv =====
// A request beat passes the operand stage (s1_ff), then the result stage (out_ff).
// Throughput: one request per cycle while the result side takes beats; the operand
// read (register file port) and the data memory port each take one register stage,
// with forwarding between items. Reset: synchronous; PC and register file read as
// zero at once, then a clearing pass zeroes data memory, during which no request is accepted.
module risc_subset_single_cycle_core #(
   parameter int unsigned DMEM_WORDS = 32
) (
   input logic        clock,
   input logic        reset,
   rscc_req_if.sink   req_chan,
   rscc_rsp_if.source rsp_chan
);
   import rscc_pkg::*;

   localparam int unsigned AW         = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
   localparam logic [31:0] DMEM_LIMIT = 32'(DMEM_WORDS);
   localparam logic [AW-1:0] LAST_IDX = AW'(DMEM_WORDS - 1);

   `include "risc_subset_single_cycle_core_assert.svh"

   // pipeline registers and state
   logic         s1_valid_ff;
   item_type     s1_ff;
   logic         out_valid_ff;
   out_type      out_ff;
   logic [31:0]  rdata_ff;
   logic [15:0]  pc_ff;
   logic [31:0]  r16_ff;
   logic         clr_busy_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic [31:0]  dmem [DMEM_WORDS];

   item_type     req_item;
   logic         req_hs;
   logic         rsp_hs;
   logic         s1_adv;
   logic [31:0]  rf_a;
   logic [31:0]  rf_b;
   logic [31:0]  op_a;
   logic [31:0]  op_b;
   logic [31:0]  out_result;
   exec_type     ex;
   logic         fault;
   logic         rd_ok;
   logic         wr_ok;
   out_type      out_in;
   rf_write_type rf_wr;

   assign req_item.req_type   = req_chan.req_type;
   assign req_item.instr_word = req_chan.instr_word;
   assign req_item.mem_index  = req_chan.mem_index;
   assign req_item.mem_value  = req_chan.mem_value;

   // handshake
   assign rsp_hs         = out_valid_ff && rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign req_hs         = req_chan.valid && req_chan.ready;

   // register file, committed when the result beat leaves
   assign rf_wr.en   = rsp_hs && out_ff.wrote;
   assign rf_wr.addr = out_ff.dest;
   assign rf_wr.data = out_result;

   rscc_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_hs),
      .rd_addr_a (req_item.instr_word[25:21]),
      .rd_addr_b (req_item.instr_word[20:16]),
      .wr        (rf_wr),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b)
   );

   // forward from the uncommitted result beat
   assign out_result = out_ff.from_mem ? rdata_ff : out_ff.value;
   assign op_a = (out_valid_ff && out_ff.wrote && out_ff.dest == s1_ff.instr_word[25:21])
                 ? out_result : rf_a;
   assign op_b = (out_valid_ff && out_ff.wrote && out_ff.dest == s1_ff.instr_word[20:16])
                 ? out_result : rf_b;

   rscc_alu u_alu (
      .item (s1_ff),
      .op_a (op_a),
      .op_b (op_b),
      .pc   (pc_ff),
      .res  (ex)
   );

   // memory range check and result stage contents
   always_comb begin
      fault             = (ex.mem_op != MEM_NONE) && (ex.mem_addr >= DMEM_LIMIT);
      rd_ok             = (ex.mem_op == MEM_READ) && !fault;
      wr_ok             = (ex.mem_op == MEM_WRITE) && !fault;
      out_in.next_pc    = ex.next_pc;
      out_in.wrote      = ex.wr_en && !fault;
      out_in.dest       = out_in.wrote ? ex.wr_dest : 5'd0;
      out_in.from_mem   = ex.show_mem && !fault;
      out_in.value      = (out_in.wrote && !out_in.from_mem) ? ex.wr_value : 32'd0;
      out_in.bad_opcode = ex.bad_opcode;
      out_in.mem_fault  = fault;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= '0;
         r16_ff       <= '0;
         clr_busy_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
      end else begin
         if (req_hs) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
            pc_ff        <= ex.next_pc;
         end else if (rsp_hs) begin
            out_valid_ff <= 1'b0;
         end
         if (rf_wr.en && rf_wr.addr == SAVED_REG) begin
            r16_ff <= rf_wr.data;
         end
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == LAST_IDX) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_hs) begin
         s1_ff <= req_item;
      end
      if (s1_adv) begin
         out_ff <= out_in;
      end
   end

   // data memory: clearing pass, then at most one access per item
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         dmem[clr_cnt_ff] <= '0;
      end else if (s1_adv && wr_ok) begin
         dmem[ex.mem_addr[AW-1:0]] <= ex.mem_data;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && rd_ok) begin
         rdata_ff <= dmem[ex.mem_addr[AW-1:0]];
      end
   end

   // result beat
   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.next_pc          = out_ff.next_pc;
   assign rsp_chan.wrote_reg        = out_ff.wrote;
   assign rsp_chan.dest_reg         = out_ff.dest;
   assign rsp_chan.result_value     = out_result;
   assign rsp_chan.saved_zero_value = (out_ff.wrote && out_ff.dest == SAVED_REG)
                                      ? out_result : r16_ff;
   assign rsp_chan.bad_opcode       = out_ff.bad_opcode;
   assign rsp_chan.mem_fault        = out_ff.mem_fault;

   // checks
   `RSCC_ASSERT_NOW(a_no_accept_while_clearing, clr_busy_ff, !req_chan.ready, "request accepted during memory clear")
   `RSCC_ASSERT_NOW(a_no_write_r0, out_valid_ff && out_ff.wrote, out_ff.dest != 5'd0, "register zero reported as written")
   `RSCC_ASSERT_NOW(a_flags_exclusive, out_valid_ff, !(out_ff.bad_opcode && out_ff.mem_fault), "bad opcode and memory fault together")
   `RSCC_ASSERT_NEXT(a_advance_fills_out, s1_adv, out_valid_ff, "advanced item missing from result stage")
   `RSCC_ASSERT_NEXT(a_mem_req_keeps_pc, s1_adv && s1_ff.req_type != REQ_EXEC, pc_ff == $past(pc_ff), "memory request changed the PC")

endmodule

// ===== tb/tb_risc_subset_single_cycle_core.sv =====
`timescale 1ns / 1ps

module tb_risc_subset_single_cycle_core;
   import rscc_pkg::*;

   localparam int unsigned DMEM_WORDS     = 32;
   localparam int          DMEM_AW        = $clog2(DMEM_WORDS);
   localparam int          RANDOM_BEATS   = 1900;
   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          HOLD_CYCLES    = 200;
   localparam int          HOLD_AFTER     = 600;

   // codes the core must not act on (the unused opcode and function are flagged bad)
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [5:0] OP_UNUSED  = 6'b111111;
   localparam logic [5:0] FN_UNUSED  = 6'b111111;

   // one retired step as the core should report it
   typedef struct packed {
      logic [15:0] next_pc;
      logic        wrote;
      logic [4:0]  dest;
      logic [31:0] value;
      logic [31:0] r16;
      logic        bad;
      logic        fault;
   } retire_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rscc_req_if req_bus ();
   rscc_rsp_if rsp_bus ();

   risc_subset_single_cycle_core #(.DMEM_WORDS(DMEM_WORDS)) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow architectural state
   logic [31:0] gpr [32];
   logic [31:0] dmem [DMEM_WORDS];
   logic [15:0] arch_pc;

   item_type   stim_q [$];
   retire_type retire_q [$];
   item_type   tx_beat;
   retire_type want;

   int items_built   = 0;
   int items_offered = 0;
   int items_taken   = 0;
   int results_seen  = 0;
   int results_paced = 0;
   int errors        = 0;
   int quiet_cycles  = 0;
   int n_taken       = 0;
   int n_fault       = 0;
   int n_bad         = 0;
   int tx_gap        = 0;
   int rx_stall      = 0;
   logic tx_burst    = 1'b0;
   logic rx_burst    = 1'b0;
   logic hold_off    = 1'b0;

   function automatic logic [31:0] r_word(input logic [4:0] rs, rt, rd, sh,
                                          input logic [5:0] fn);
      return {OP_RTYPE, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs, rt,
                                          input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   // unused fields carry random bits
   function automatic item_type exec_item(input logic [31:0] word);
      item_type it;
      it.req_type   = REQ_EXEC;
      it.instr_word = word;
      it.mem_index  = 5'($urandom_range(0, 31));
      it.mem_value  = $urandom;
      return it;
   endfunction

   function automatic item_type data_item(input logic [1:0] kind, input logic [4:0] idx,
                                          input logic [31:0] val);
      item_type it;
      it.req_type   = kind;
      it.instr_word = $urandom;
      it.mem_index  = idx;
      it.mem_value  = val;
      return it;
   endfunction

   // Advance the shadow core by one request and return what it should report
   function automatic retire_type compute_retire(input item_type it);
      retire_type  r;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sh, wdest;
      logic [31:0] a, b, imm, wval, addr;
      logic [15:0] pc1;
      logic        wr;
      r     = '0;
      wr    = 1'b0;
      wdest = '0;
      wval  = '0;
      case (it.req_type)
         REQ_EXEC: begin
            op  = it.instr_word[31:26];
            rs  = it.instr_word[25:21];
            rt  = it.instr_word[20:16];
            rd  = it.instr_word[15:11];
            sh  = it.instr_word[10:6];
            fn  = it.instr_word[5:0];
            imm = {{16{it.instr_word[15]}}, it.instr_word[15:0]};
            a   = (rs == 5'd0) ? 32'd0 : gpr[rs];
            b   = (rt == 5'd0) ? 32'd0 : gpr[rt];
            pc1 = arch_pc + 16'd1;
            arch_pc = pc1;
            if (op == OP_RTYPE) begin
               wdest = rd;
               wr    = 1'b1;
               case (fn)
                  FN_ADD: wval = a + b;
                  FN_SUB: wval = a - b;
                  FN_SLL: wval = b << sh;
                  FN_SLT: wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                  default: begin
                     wr    = 1'b0;
                     r.bad = 1'b1;
                  end
               endcase
            end else if (op == OP_ADDI) begin
               wr    = 1'b1;
               wdest = rt;
               wval  = a + imm;
            end else if (op == OP_BEQ || op == OP_BNE) begin
               if ((op == OP_BEQ) == (a == b)) begin
                  arch_pc = pc1 + imm[15:0];
                  n_taken++;
               end
            end else if (op == OP_LW || op == OP_SW) begin
               addr = a + imm;
               if (addr >= DMEM_WORDS) begin
                  r.fault = 1'b1;
               end else if (op == OP_LW) begin
                  wr    = 1'b1;
                  wdest = rt;
                  wval  = dmem[addr[DMEM_AW-1:0]];
               end else begin
                  dmem[addr[DMEM_AW-1:0]] = b;
               end
            end else begin
               r.bad = 1'b1;
            end
            // r0 writes are dropped and reported as no write
            if (wr && wdest != 5'd0) begin
               gpr[wdest] = wval;
               r.wrote    = 1'b1;
               r.dest     = wdest;
               r.value    = wval;
            end
         end
         REQ_LOAD: begin
            if (it.mem_index >= DMEM_WORDS) r.fault = 1'b1;
            else dmem[it.mem_index] = it.mem_value;
         end
         REQ_READ: begin
            if (it.mem_index >= DMEM_WORDS) r.fault = 1'b1;
            else r.value = dmem[it.mem_index];
         end
         default: ;
      endcase
      r.next_pc = arch_pc;
      r.r16     = gpr[SAVED_REG];
      if (r.bad) n_bad++;
      if (r.fault) n_fault++;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_val,
                  act_val);
         errors++;
      end
   endtask

   // Request driver: new beat at a falling edge once the last one was taken and a random gap ran out
   always @(negedge clock) begin
      if (!reset && items_taken == items_offered) begin
         if (tx_gap > 0) begin
            req_bus.valid <= 1'b0;
            tx_gap--;
         end else if (stim_q.size() != 0) begin
            tx_beat = stim_q.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.req_type   <= tx_beat.req_type;
            req_bus.instr_word <= tx_beat.instr_word;
            req_bus.mem_index  <= tx_beat.mem_index;
            req_bus.mem_value  <= tx_beat.mem_value;
            items_offered++;
            if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
            tx_gap = tx_burst ? 0 : $urandom_range(0, 5);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Accepted request beats go through the shadow core
   always @(posedge clock) begin
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
         retire_q.push_back(compute_retire({req_bus.req_type, req_bus.instr_word,
                                            req_bus.mem_index, req_bus.mem_value}));
         items_taken++;
      end
   end

   // Result ready: random stall after each beat, plus the long hold-off
   always @(negedge clock) begin
      if (results_paced != results_seen) begin
         results_paced = results_seen;
         if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
         rx_stall = rx_burst ? 0 : $urandom_range(0, 5);
      end
      if (reset || hold_off) begin
         rsp_bus.ready <= 1'b0;
      end else if (rx_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rx_stall--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         if (retire_q.size() == 0) begin
            $display("%0t ns: result beat with nothing expected, pc %h value %h", $time,
                     rsp_bus.next_pc, rsp_bus.result_value);
            errors++;
         end else begin
            want = retire_q.pop_front();
            check_field("next_pc", 32'(want.next_pc), 32'(rsp_bus.next_pc));
            check_field("wrote_reg", 32'(want.wrote), 32'(rsp_bus.wrote_reg));
            check_field("dest_reg", 32'(want.dest), 32'(rsp_bus.dest_reg));
            check_field("result_value", want.value, rsp_bus.result_value);
            check_field("saved_zero_value", want.r16, rsp_bus.saved_zero_value);
            check_field("bad_opcode", 32'(want.bad), 32'(rsp_bus.bad_opcode));
            check_field("mem_fault", 32'(want.fault), 32'(rsp_bus.mem_fault));
         end
      end
   end

   // Watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no beat for %0d cycles, giving up", $time, quiet_cycles);
         $display("[risc_subset_single_cycle_core] ERROR");
         $finish;
      end
   end

   // Long back-pressure stretch so the core fills and stalls its input
   initial begin
      wait (items_taken >= HOLD_AFTER);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      int          sel;
      int          mode;
      logic [4:0]  rs, rt, rd, sh;
      logic [5:0]  op, fn;
      logic [15:0] imm;

      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_EXEC;
      req_bus.instr_word = '0;
      req_bus.mem_index  = '0;
      req_bus.mem_value  = '0;
      rsp_bus.ready      = 1'b0;
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      for (int i = 0; i < DMEM_WORDS; i++) dmem[i] = '0;
      arch_pc = '0;

      // directed: immediates and data at their extremes, every operation,
      // r0 writes, faults on both memory ops, branches both ways, bad codes
      stim_q.push_back(exec_item(i_word(OP_ADDI, 5'd0, 5'd1, 16'h7FFF)));
      stim_q.push_back(exec_item(i_word(OP_ADDI, 5'd0, 5'd2, 16'h8000)));
      stim_q.push_back(data_item(REQ_LOAD, 5'd0, 32'h7FFF_FFFF));
      stim_q.push_back(data_item(REQ_LOAD, 5'd31, 32'h8000_0000));
      stim_q.push_back(exec_item(i_word(OP_LW, 5'd0, 5'd3, 16'd0)));
      stim_q.push_back(exec_item(i_word(OP_LW, 5'd0, 5'd4, 16'd31)));
      stim_q.push_back(exec_item(r_word(5'd3, 5'd3, 5'd5, 5'd0, FN_ADD)));
      stim_q.push_back(exec_item(r_word(5'd4, 5'd1, 5'd6, 5'd0, FN_SUB)));
      stim_q.push_back(exec_item(r_word(5'd0, 5'd3, 5'd7, 5'd31, FN_SLL)));
      stim_q.push_back(exec_item(r_word(5'd31, 5'd4, 5'd8, 5'd0, FN_SLL)));
      stim_q.push_back(exec_item(r_word(5'd4, 5'd3, 5'd9, 5'd0, FN_SLT)));
      stim_q.push_back(exec_item(r_word(5'd3, 5'd4, 5'd10, 5'd0, FN_SLT)));
      stim_q.push_back(exec_item(r_word(5'd3, 5'd3, 5'd0, 5'd0, FN_ADD)));
      stim_q.push_back(exec_item(i_word(OP_ADDI, 5'd0, SAVED_REG, 16'hFFFF)));
      stim_q.push_back(exec_item(i_word(OP_SW, 5'd0, 5'd2, 16'd5)));
      stim_q.push_back(data_item(REQ_READ, 5'd5, $urandom));
      stim_q.push_back(exec_item(i_word(OP_SW, SAVED_REG, 5'd1, 16'd0)));
      stim_q.push_back(exec_item(i_word(OP_LW, 5'd0, 5'd11, 16'd32)));
      stim_q.push_back(exec_item(i_word(OP_BEQ, 5'd0, 5'd0, 16'hFFFF)));
      stim_q.push_back(exec_item(i_word(OP_BNE, 5'd3, 5'd4, 16'h8000)));
      stim_q.push_back(exec_item(i_word(OP_BEQ, 5'd3, 5'd4, 16'h7FFF)));
      stim_q.push_back(exec_item(i_word(OP_BNE, 5'd1, 5'd1, 16'h0001)));
      stim_q.push_back(exec_item({OP_UNUSED, 26'($urandom)}));
      stim_q.push_back(exec_item(r_word(5'd1, 5'd2, 5'd12, 5'd3, FN_UNUSED)));
      stim_q.push_back(data_item(REQ_UNUSED, 5'($urandom), $urandom));
      stim_q.push_back(data_item(REQ_READ, 5'd31, $urandom));

      // random: mostly legal instructions with random operands
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         sel = $urandom_range(0, 99);
         rs  = 5'($urandom_range(0, 31));
         rt  = 5'($urandom_range(0, 31));
         rd  = 5'($urandom_range(0, 31));
         sh  = 5'($urandom_range(0, 31));
         imm = 16'($urandom_range(0, 65535));
         if (sel < 30) begin
            case ($urandom_range(0, 3))
               0: fn = FN_ADD;
               1: fn = FN_SUB;
               2: fn = FN_SLL;
               default: fn = FN_SLT;
            endcase
            stim_q.push_back(exec_item(r_word(rs, rt, rd, sh, fn)));
         end else if (sel < 42) begin
            // small immediates half the time so registers make usable bases
            if ($urandom_range(0, 1) == 1) imm = 16'($urandom_range(0, 31));
            stim_q.push_back(exec_item(i_word(OP_ADDI, rs, rt, imm)));
         end else if (sel < 52) begin
            if ($urandom_range(0, 2) == 0) rt = rs;
            op = ($urandom_range(0, 1) == 1) ? OP_BEQ : OP_BNE;
            stim_q.push_back(exec_item(i_word(op, rs, rt, imm)));
         end else if (sel < 70) begin
            // mostly direct in-range words, some base+offset, some wild offsets
            mode = $urandom_range(0, 9);
            if (mode >= 3) begin
               rs  = 5'd0;
               imm = 16'($urandom_range(0, DMEM_WORDS - 1));
            end else if (mode != 0) begin
               imm = 16'($urandom_range(0, 7));
            end
            op = ($urandom_range(0, 1) == 1) ? OP_LW : OP_SW;
            stim_q.push_back(exec_item(i_word(op, rs, rt, imm)));
         end else if (sel < 78) begin
            stim_q.push_back(data_item(REQ_LOAD, 5'($urandom), $urandom));
         end else if (sel < 86) begin
            stim_q.push_back(data_item(REQ_READ, 5'($urandom), $urandom));
         end else if (sel < 90) begin
            stim_q.push_back(data_item(REQ_UNUSED, 5'($urandom), $urandom));
         end else if (sel < 95) begin
            if ($urandom_range(0, 1) == 1) begin
               do op = 6'($urandom_range(0, 63));
               while (op == OP_RTYPE || op == OP_ADDI || op == OP_BEQ || op == OP_BNE ||
                      op == OP_LW || op == OP_SW);
               stim_q.push_back(exec_item({op, 26'($urandom)}));
            end else begin
               do fn = 6'($urandom_range(0, 63));
               while (fn == FN_ADD || fn == FN_SUB || fn == FN_SLL || fn == FN_SLT);
               stim_q.push_back(exec_item(r_word(rs, rt, rd, sh, fn)));
            end
         end else begin
            stim_q.push_back(exec_item($urandom));
         end
      end
      items_built = stim_q.size();

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      while (items_taken != items_built) @(posedge clock);
      while (retire_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Ran %0d request beats: %0d taken branches, %0d memory faults, %0d bad codes.",
               items_taken, n_taken, n_fault, n_bad);
      $display("Both sides idled at random; results were held off for %0d cycles once.",
               HOLD_CYCLES);
      if (errors == 0) begin
         $display("[risc_subset_single_cycle_core] OK");
      end else begin
         $display("[risc_subset_single_cycle_core] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/rscc_pkg.sv
sv/rscc_if.sv
sv/rscc_regfile.sv
sv/rscc_alu.sv
sv/risc_subset_single_cycle_core.sv
tb/tb_risc_subset_single_cycle_core.sv
